>>> design/sfls_pkg.sv
// Shared parameters, codes and types of the smooth FFT length search.
package sfls_pkg;

   localparam int LENGTH_BITS_DEFAULT = 24;

   typedef enum logic [1:0] {
      MODE_NEXT  = 2'd0,
      MODE_EVEN  = 2'd1,
      MODE_PREV  = 2'd2,
      MODE_CLAMP = 2'd3
   } mode_type;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NO_LENGTH = 1'b1;

   // Per-cycle control from the candidate walker to the best-value tracker.
   typedef struct packed {
      logic valid;   // value carries a smooth candidate this cycle
      logic done;    // last candidate of the sweep
   } walk_ctl_type;

endpackage

>>> design/sfls_walk.sv
// Candidate walker: steps through 2^a * 3^b * 5^c * 7^d values up to the search limit.
module sfls_walk
   import sfls_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [LENGTH_BITS-1:0]   limit,
   output walk_ctl_type             ctl,
   output logic [LENGTH_BITS+2:0]   value
);

   localparam int W = LENGTH_BITS + 3;

   logic         busy_ff, busy_in;
   logic [W-1:0] v_ff, v_in;
   logic [W-1:0] m_ff, m_in;
   logic [W-1:0] m5_ff, m5_in;
   logic [W-1:0] m7_ff, m7_in;
   logic         first_ff, first_in;
   logic         first_b_ff, first_b_in;
   logic         first_c_ff, first_c_in;
   logic         m_big_ff, m_big_in;
   logic         m5_big_ff, m5_big_in;
   logic         m7_big_ff, m7_big_in;

   logic         big;
   logic         m_big;
   logic         m5_big;
   logic         m7_big;
   logic [W-1:0] lim_w;
   logic [W-1:0] times3;
   logic [W-1:0] times5;
   logic [W-1:0] times7;

   always_comb begin
      lim_w  = W'(limit);
      big    = (v_ff >= lim_w);
      // first value of a chain is its odd part itself
      m_big  = first_ff ? big : m_big_ff;
      m5_big = (first_ff && first_b_ff) ? big : m5_big_ff;
      m7_big = (first_ff && first_b_ff && first_c_ff) ? big : m7_big_ff;
      times3 = (m_ff << 1) + m_ff;
      times5 = (m5_ff << 2) + m5_ff;
      times7 = (m7_ff << 3) - m7_ff;

      busy_in    = busy_ff;
      v_in       = v_ff;
      m_in       = m_ff;
      m5_in      = m5_ff;
      m7_in      = m7_ff;
      first_in   = first_ff;
      first_b_in = first_b_ff;
      first_c_in = first_c_ff;
      m_big_in   = m_big;
      m5_big_in  = m5_big;
      m7_big_in  = m7_big;

      if (start) begin
         busy_in    = 1'b1;
         v_in       = W'(1);
         m_in       = W'(1);
         m5_in      = W'(1);
         m7_in      = W'(1);
         first_in   = 1'b1;
         first_b_in = 1'b1;
         first_c_in = 1'b1;
      end else if (busy_ff) begin
         if (!big) begin
            // double along the chain
            v_in     = v_ff << 1;
            first_in = 1'b0;
         end else if (!m_big) begin
            m_in       = times3;
            v_in       = times3;
            first_in   = 1'b1;
            first_b_in = 1'b0;
            first_c_in = 1'b0;
         end else if (!m5_big) begin
            m5_in      = times5;
            m_in       = times5;
            v_in       = times5;
            first_in   = 1'b1;
            first_b_in = 1'b1;
            first_c_in = 1'b0;
         end else if (!m7_big) begin
            m7_in      = times7;
            m5_in      = times7;
            m_in       = times7;
            v_in       = times7;
            first_in   = 1'b1;
            first_b_in = 1'b1;
            first_c_in = 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   assign ctl.valid = busy_ff;
   assign ctl.done  = busy_ff & big & m_big & m5_big & m7_big;
   assign value     = v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      v_ff       <= v_in;
      m_ff       <= m_in;
      m5_ff      <= m5_in;
      m7_ff      <= m7_in;
      first_ff   <= first_in;
      first_b_ff <= first_b_in;
      first_c_ff <= first_c_in;
      m_big_ff   <= m_big_in;
      m5_big_ff  <= m5_big_in;
      m7_big_ff  <= m7_big_in;
   end

endmodule

>>> design/sfls_track.sv
// Best-value tracker: keeps the least candidate at or above the target and the
// greatest candidate below the bound.
module sfls_track
   import sfls_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     clear,
   input  walk_ctl_type             ctl,
   input  logic [LENGTH_BITS+2:0]   value,
   input  logic [LENGTH_BITS-1:0]   target,
   input  logic [LENGTH_BITS-1:0]   bound,
   output logic [LENGTH_BITS+2:0]   best_next,
   output logic [LENGTH_BITS+2:0]   best_prev
);

   localparam int W = LENGTH_BITS + 3;

   logic [W-1:0] next_ff, next_in;
   logic [W-1:0] prev_ff, prev_in;

   always_comb begin
      next_in = next_ff;
      prev_in = prev_ff;
      if (clear) begin
         next_in = '1;
         prev_in = '0;
      end else if (ctl.valid) begin
         if ((value >= W'(target)) && (value < next_ff)) begin
            next_in = value;
         end
         if ((value < W'(bound)) && (value > prev_ff)) begin
            prev_in = value;
         end
      end
   end

   assign best_next = next_ff;
   assign best_prev = prev_ff;

   always_ff @(posedge clock) begin
      next_ff <= next_in;
      prev_ff <= prev_in;
   end

endmodule

>>> design/smooth_fft_length_search.sv
// Candidates are the 7-smooth values below the search limit (the count, half of it in
// the even mode, at least the cap in the clamped mode) plus one per odd part
// 3^b*5^c*7^d reached. A new item is taken only once the previous search has
// finished; the result load waits while the previous result is not taken.
// Reset: synchronous, active high; cap returns to all ones.
module smooth_fft_length_search
   import sfls_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((LENGTH_BITS+7)/8)*8-1:0]       req_tdata,  // requested_length
   input  logic [1:0]                             req_tuser,  // mode
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((LENGTH_BITS+8)/8)*8-1:0]       rsp_tdata,  // length
   output logic [1:0]                             rsp_tuser,  // status, clamped
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [LENGTH_BITS-1:0]                 csr_data
);

   localparam int L     = LENGTH_BITS;
   localparam int W     = LENGTH_BITS + 3;
   localparam int RSP_W = ((LENGTH_BITS + 8) / 8) * 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type    state_ff, state_in;
   mode_type     mode_ff, mode_in;
   logic [L-1:0] target_ff, target_in;
   logic [L-1:0] bound_ff, bound_in;
   logic [L-1:0] limit_ff, limit_in;
   logic [L-1:0] length_cap_ff, length_cap_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [L:0]   rsp_len_ff, rsp_len_in;
   logic         rsp_status_ff, rsp_status_in;
   logic         rsp_clamped_ff, rsp_clamped_in;

   logic         req_take;
   logic         start;
   mode_type     req_mode;
   logic [L-1:0] req_len;
   logic [L-1:0] len1;
   logic [L:0]   len1_inc;
   logic [L-1:0] half;
   logic [L-1:0] t_new;
   logic [L-1:0] b_new;
   logic [L:0]   nxt;
   logic [L:0]   prv;
   logic         prv_fail;

   walk_ctl_type walk_ctl;
   logic [W-1:0] walk_value;
   logic [W-1:0] best_next;
   logic [W-1:0] best_prev;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_take   = req_tvalid & req_tready;
   assign start      = req_take;

   always_comb begin
      req_mode = mode_type'(req_tuser);
      req_len  = req_tdata[L-1:0];
      len1     = (req_len == '0) ? L'(1) : req_len;
      len1_inc = {1'b0, len1} + (L+1)'(1);
      half     = len1_inc[L:1];
      nxt      = best_next[L:0];
      prv      = best_prev[L:0];
      prv_fail = (best_prev == '0);

      unique case (req_mode)
         MODE_NEXT: begin
            t_new = len1;
            b_new = '0;
         end
         MODE_EVEN: begin
            // even smooth = 2 * smooth at or above half the count
            t_new = half;
            b_new = '0;
         end
         MODE_PREV: begin
            t_new = '0;
            b_new = req_len;
         end
         MODE_CLAMP: begin
            t_new = len1;
            b_new = length_cap_ff;
         end
         default: begin
            t_new = len1;
            b_new = '0;
         end
      endcase

      state_in       = state_ff;
      mode_in        = mode_ff;
      target_in      = target_ff;
      bound_in       = bound_ff;
      limit_in       = limit_ff;
      length_cap_in  = length_cap_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_clamped_in = rsp_clamped_ff;

      if (csr_valid) begin
         length_cap_in = csr_data;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mode_in   = req_mode;
               target_in = t_new;
               bound_in  = b_new;
               limit_in  = (t_new > b_new) ? t_new : b_new;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            if (walk_ctl.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output slot is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STATUS_OK;
               rsp_clamped_in = 1'b0;
               unique case (mode_ff)
                  MODE_NEXT: begin
                     rsp_len_in = nxt;
                  end
                  MODE_EVEN: begin
                     rsp_len_in = {nxt[L-1:0], 1'b0};
                  end
                  MODE_PREV: begin
                     rsp_len_in    = prv;
                     rsp_status_in = prv_fail ? STATUS_NO_LENGTH : STATUS_OK;
                  end
                  MODE_CLAMP: begin
                     if (nxt > {1'b0, length_cap_ff}) begin
                        rsp_len_in     = prv;
                        rsp_status_in  = prv_fail ? STATUS_NO_LENGTH : STATUS_OK;
                        rsp_clamped_in = !prv_fail;
                     end else begin
                        rsp_len_in = nxt;
                     end
                  end
                  default: begin
                     rsp_len_in = nxt;
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         length_cap_ff <= '1;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         length_cap_ff <= length_cap_in;
      end
      mode_ff        <= mode_in;
      target_ff      <= target_in;
      bound_ff       <= bound_in;
      limit_ff       <= limit_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   sfls_walk #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_walk (
      .clock (clock),
      .reset (reset),
      .start (start),
      .limit (limit_in),
      .ctl   (walk_ctl),
      .value (walk_value)
   );

   sfls_track #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_track (
      .clock     (clock),
      .clear     (start),
      .ctl       (walk_ctl),
      .value     (walk_value),
      .target    (target_ff),
      .bound     (bound_ff),
      .best_next (best_next),
      .best_prev (best_prev)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_len_ff);
   assign rsp_tuser  = {rsp_clamped_ff, rsp_status_ff};

   // A failed search always reports length zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_NO_LENGTH)) |-> (rsp_len_ff == '0))
      else $error("failed search with nonzero length");

   // A clamped result lies strictly below the configured cap.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clamped_ff) |-> (rsp_len_ff < {1'b0, length_cap_ff}))
      else $error("clamped length not below the cap");

   // The walker only produces candidates while a search runs.
   assert property (@(posedge clock) disable iff (reset)
      walk_ctl.valid |-> (state_ff == ST_RUN))
      else $error("walker active outside a search");

   // An accepted item starts a search on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_RUN) && walk_ctl.valid)
      else $error("search did not start after accept");

endmodule

>>> dv/smooth_fft_length_search_tb.sv
// Self-checking testbench for the 2-3-5-7 smooth FFT length search.
module smooth_fft_length_search_tb
   import sfls_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LENGTH_BITS    = 24;
   localparam int REQ_BITS       = ((LENGTH_BITS + 7) / 8) * 8;
   localparam int RSP_BITS       = ((LENGTH_BITS + 8) / 8) * 8;
   localparam int IDLE_PERCENT   = 24;
   localparam int NUM_PHASES     = 7;
   localparam int PHASE_ITEMS    = 276;
   localparam int STEADY_FIRST   = 900;
   localparam int STEADY_LAST    = 1200;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 40;
   localparam int PRINT_LIMIT    = 50;
   localparam int NUM_DIRECTED   = 22;
   localparam longint unsigned TABLE_TOP = 64'd1 << (LENGTH_BITS + 1);
   localparam logic [LENGTH_BITS-1:0] ALL_ONES = '1;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct packed {
      logic [24:0] length;
      logic        status;
      logic        clamped;
   } length_result_type;

   typedef struct {
      mode_type               mode;
      logic [LENGTH_BITS-1:0] count;
      length_result_type      want;
   } pending_search_type;

   typedef struct packed {
      row_kind_type           kind;
      mode_type               mode;
      logic [LENGTH_BITS-1:0] value;
      logic                   typed;
      logic [24:0]            want_length;
      logic                   want_status;
      logic                   want_clamped;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_BITS-1:0]    req_tdata = '0;   // requested_length
   logic [1:0]             req_tuser = '0;   // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]    rsp_tdata;        // length
   logic [1:0]             rsp_tuser;        // status, clamped
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [LENGTH_BITS-1:0] csr_data = '0;

   logic                   steady = 1'b0;
   int                     mismatch_count = 0;
   int                     stuck_cycles = 0;
   logic [LENGTH_BITS-1:0] length_cap_cfg;
   longint unsigned        smooth_lengths [$];
   pending_search_type     pending_searches [$];
   directed_row_type       directed_rows [NUM_DIRECTED];

   smooth_fft_length_search #(
      .LENGTH_BITS(LENGTH_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every 2^a 3^b 5^c 7^d up to 2^(LENGTH_BITS+1), in no particular order.
   function automatic void build_smooth_lengths();
      longint unsigned p2, p3, p5, p7;
      for (p2 = 64'd1; p2 <= TABLE_TOP; p2 = p2 * 64'd2)
         for (p3 = p2; p3 <= TABLE_TOP; p3 = p3 * 64'd3)
            for (p5 = p3; p5 <= TABLE_TOP; p5 = p5 * 64'd5)
               for (p7 = p5; p7 <= TABLE_TOP; p7 = p7 * 64'd7)
                  smooth_lengths.push_back(p7);
   endfunction

   function automatic longint unsigned least_smooth_from(longint unsigned floor_value,
                                                         bit even_only);
      longint unsigned best;
      best = 64'd0;
      if (floor_value == 64'd0)
         floor_value = 64'd1;
      for (int i = 0; i < smooth_lengths.size(); i++) begin
         if (smooth_lengths[i] >= floor_value && (!even_only || !smooth_lengths[i][0]) &&
             (best == 64'd0 || smooth_lengths[i] < best))
            best = smooth_lengths[i];
      end
      return best;
   endfunction

   // Zero means no smooth length lies below the bound.
   function automatic longint unsigned greatest_smooth_below(longint unsigned bound);
      longint unsigned best;
      best = 64'd0;
      for (int i = 0; i < smooth_lengths.size(); i++) begin
         if (smooth_lengths[i] < bound && smooth_lengths[i] > best)
            best = smooth_lengths[i];
      end
      return best;
   endfunction

   function automatic length_result_type search_length(mode_type mode,
                                                       logic [LENGTH_BITS-1:0] count);
      length_result_type res;
      longint unsigned   found;
      res = '0;
      case (mode)
         MODE_NEXT: begin
            found = least_smooth_from(64'(count), 1'b0);
         end
         MODE_EVEN: begin
            found = least_smooth_from(64'(count), 1'b1);
         end
         MODE_PREV: begin
            found = greatest_smooth_below(64'(count));
            res.status = (found == 64'd0) ? STATUS_NO_LENGTH : STATUS_OK;
         end
         default: begin
            found = least_smooth_from(64'(count), 1'b0);
            if (found > 64'(length_cap_cfg)) begin
               found = greatest_smooth_below(64'(length_cap_cfg));
               res.status  = (found == 64'd0) ? STATUS_NO_LENGTH : STATUS_OK;
               res.clamped = (found != 64'd0);
            end
         end
      endcase
      res.length = found[24:0];
      return res;
   endfunction

   // Mostly short counts keep the search cheap; a few span the whole field.
   function automatic logic [LENGTH_BITS-1:0] pick_count();
      int unsigned     sel;
      longint unsigned value;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         value = 64'($urandom_range(0, 2000));
      end else if (sel < 78) begin
         value = 64'($urandom_range(0, 100000));
      end else if (sel < 84) begin
         value = 64'($urandom() & 32'(ALL_ONES));
      end else if (sel < 94) begin
         do
            value = smooth_lengths[$urandom_range(0, smooth_lengths.size() - 1)];
         while (value > 64'd65536);
         value = value + 64'($urandom_range(0, 2)) - 64'd1;
      end else begin
         case ($urandom_range(0, 3))
            0: value = 64'd0;
            1: value = 64'd1;
            2: value = 64'd2;
            default: value = 64'(ALL_ONES);
         endcase
      end
      return value[LENGTH_BITS-1:0];
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_result();
      pending_search_type exp;
      if (pending_searches.size() == 0) begin
         report_mismatch($sformatf("result with no item waiting: length %0d",
                                   rsp_tdata[24:0]));
         return;
      end
      exp = pending_searches.pop_front();
      if (rsp_tdata[24:0] !== exp.want.length)
         report_mismatch($sformatf("mode %0d count %0d: length %0d, predicted %0d",
                                   exp.mode, exp.count, rsp_tdata[24:0], exp.want.length));
      if (rsp_tuser[0] !== exp.want.status)
         report_mismatch($sformatf("mode %0d count %0d: status %b, predicted %b",
                                   exp.mode, exp.count, rsp_tuser[0], exp.want.status));
      if (rsp_tuser[1] !== exp.want.clamped)
         report_mismatch($sformatf("mode %0d count %0d: clamped %b, predicted %b",
                                   exp.mode, exp.count, rsp_tuser[1], exp.want.clamped));
   endtask

   task automatic send_search(mode_type mode, logic [LENGTH_BITS-1:0] count,
                              length_result_type want);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'(count);
      req_tuser  <= mode;
      do
         @(posedge clock);
      while (!req_tready);
      pending_searches.push_back('{mode, count, want});
   endtask

   // Hold the sender until every outstanding result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_searches.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_length_cap(logic [LENGTH_BITS-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid      <= 1'b0;
      length_cap_cfg = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready   <= 1'b0;
         stuck_cycles <= 0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
         if (rsp_tvalid && rsp_tready)
            check_result();
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   initial begin
      mode_type               mode;
      logic [LENGTH_BITS-1:0] count;
      logic [LENGTH_BITS-1:0] phase_max;
      int                     item_index;

      length_cap_cfg = ALL_ONES;
      build_smooth_lengths();
      directed_rows = '{
         '{ROW_ITEM, MODE_NEXT,  24'd0,    1'b1, 25'd1,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_NEXT,  24'd1,    1'b1, 25'd1,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_NEXT,  ALL_ONES, 1'b1, 25'h1000000, STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_NEXT,  24'd11,   1'b0, 25'd0,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_EVEN,  24'd0,    1'b1, 25'd2,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_EVEN,  ALL_ONES, 1'b1, 25'h1000000, STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_EVEN,  24'd9,    1'b0, 25'd0,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_PREV,  24'd0,    1'b1, 25'd0,       STATUS_NO_LENGTH, 1'b0},
         '{ROW_ITEM, MODE_PREV,  24'd1,    1'b1, 25'd0,       STATUS_NO_LENGTH, 1'b0},
         '{ROW_ITEM, MODE_PREV,  24'd2,    1'b1, 25'd1,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_PREV,  ALL_ONES, 1'b0, 25'd0,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_CLAMP, 24'd0,    1'b1, 25'd1,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_CLAMP, ALL_ONES, 1'b0, 25'd0,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_CLAMP, 24'd1000, 1'b0, 25'd0,       STATUS_OK,        1'b0},
         '{ROW_CSR,  MODE_NEXT,  24'd1,    1'b0, 25'd0,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_CLAMP, 24'd0,    1'b1, 25'd1,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_CLAMP, 24'd2,    1'b1, 25'd0,       STATUS_NO_LENGTH, 1'b0},
         '{ROW_CSR,  MODE_NEXT,  24'd0,    1'b0, 25'd0,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_CLAMP, 24'd0,    1'b1, 25'd0,       STATUS_NO_LENGTH, 1'b0},
         '{ROW_CSR,  MODE_NEXT,  24'd1000, 1'b0, 25'd0,       STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_CLAMP, 24'd1000, 1'b1, 25'd1000,    STATUS_OK,        1'b0},
         '{ROW_ITEM, MODE_CLAMP, 24'd1001, 1'b0, 25'd0,       STATUS_OK,        1'b0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < NUM_DIRECTED; r++) begin
         if (directed_rows[r].kind == ROW_CSR)
            write_length_cap(directed_rows[r].value);
         else if (directed_rows[r].typed)
            send_search(directed_rows[r].mode, directed_rows[r].value,
                        '{directed_rows[r].want_length, directed_rows[r].want_status,
                          directed_rows[r].want_clamped});
         else
            send_search(directed_rows[r].mode, directed_rows[r].value,
                        search_length(directed_rows[r].mode, directed_rows[r].value));
      end

      item_index = 0;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: phase_max = '0;
            1: phase_max = LENGTH_BITS'(1);
            2: phase_max = LENGTH_BITS'($urandom_range(2, 3000));
            3: phase_max = LENGTH_BITS'($urandom_range(3000, 100000));
            4: phase_max = ALL_ONES;
            5: phase_max = LENGTH_BITS'($urandom() & 32'(ALL_ONES));
            default: phase_max = LENGTH_BITS'($urandom_range(2, 200));
         endcase
         write_length_cap(phase_max);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // in phase 3 only, hold off once mid-phase until the block has fully drained
            if (phase == 3 && n == PHASE_ITEMS / 2)
               drain_results();
            steady <= (item_index >= STEADY_FIRST && item_index < STEADY_LAST);
            mode  = mode_type'(2'($urandom_range(0, 3)));
            count = pick_count();
            send_search(mode, count, search_length(mode, count));
            item_index++;
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> sim.f
design/sfls_pkg.sv
design/sfls_walk.sv
design/sfls_track.sv
design/smooth_fft_length_search.sv
dv/smooth_fft_length_search_tb.sv
